/* hdl/abs_pkg.sv */
// Shared types, constants and helpers of the alignment block segmenter.
package abs_pkg;

  // Field widths.
  localparam int unsigned CoordW  = 31;
  localparam int unsigned SumW    = 32;
  localparam int unsigned PermW   = 10;
  localparam int unsigned CfgIdxW = 2;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CFG_MAX_GAP  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MIN_SPAN = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIN_ALI  = 2'd2;

  // Register values after reset.
  localparam logic [CoordW-1:0] MAX_GAP_RST  = 31'd5000;
  localparam logic [CoordW-1:0] MIN_SPAN_RST = 31'd5000;
  localparam logic [PermW-1:0]  MIN_ALI_RST  = 10'd300;

  // Score scale: one thousand.
  localparam logic [PermW-1:0] SCORE_MAX = 10'd1000;

  typedef logic [CoordW-1:0] coord_t;
  typedef logic [SumW-1:0]   sum_t;
  typedef logic [PermW-1:0]  perm_t;

  // One input beat: a gapless block of the chain.
  typedef struct packed {
    coord_t t_start;
    coord_t t_end;
    coord_t q_start;
    coord_t q_end;
    coord_t matched_bases;
    logic   query_minus;
    logic   chain_last;
  } blk_item_t;

  // One output beat: an emitted segment.
  typedef struct packed {
    coord_t seg_start;
    coord_t seg_end;
    perm_t  identity_score;
    logic   seg_minus;
    logic   run_last;
  } seg_item_t;

  // One configuration write beat.
  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    coord_t             wdata;
  } cfg_beat_t;

  // Configuration register file contents.
  typedef struct packed {
    coord_t max_gap;
    coord_t min_span;
    perm_t  min_ali_permille;
  } cfg_t;

  // A segment to be closed, handed from the front to the back.
  typedef struct packed {
    coord_t first_t;
    coord_t end_t;
    sum_t   aligned;
    sum_t   matched;
    logic   minus;
    logic   last_job;
  } job_t;

  // Saturating 32-bit add.
  function automatic sum_t sat_add(sum_t a, sum_t b);
    logic [SumW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SumW] ? '1 : s[SumW-1:0];
  endfunction

endpackage

/* hdl/abs_if.sv */
// Valid/ready channel interfaces for blocks, segments and configuration writes.
interface abs_blk_if;
  import abs_pkg::*;
  logic      valid;
  logic      ready;
  blk_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface abs_seg_if;
  import abs_pkg::*;
  logic      valid;
  logic      ready;
  seg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface abs_cfg_if;
  import abs_pkg::*;
  logic      valid;
  logic      ready;
  cfg_beat_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* hdl/alignment_block_segmenter_top.sv */
// Top level of the alignment block segmenter: registers, front, queue and back.
//
//   channel  modport  beat
//   blk_i    sink     one gapless block of a chain
//   seg_o    source   one emitted segment with its identity score
//   cfg_i    sink     one register write (index, data)
//
// The front takes no new block until it has finished the last, and a chain end adds
// a close state. The back drops a segment that fails its checks; one it emits runs the
// score divider unless its score is zero or saturated, and a held first segment is
// sent out ahead of it. The back takes no new segment until it is through with the last.
// Reset clears the segment state, the queue and the output; registers take defaults.
// A stalled output fills the queue and then holds the front.
module alignment_block_segmenter_top (
  input logic       clk_i,
  input logic       rst_ni,
  abs_blk_if.sink   blk_i,
  abs_seg_if.source seg_o,
  abs_cfg_if.sink   cfg_i
);
  import abs_pkg::*;

  cfg_t cfg_q;
  logic push_valid, push_ready, pop_valid, pop_ready;
  job_t push_job, pop_job;

  assign cfg_i.ready = 1'b1;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_gap          <= MAX_GAP_RST;
      cfg_q.min_span         <= MIN_SPAN_RST;
      cfg_q.min_ali_permille <= MIN_ALI_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.data.index)
        CFG_MAX_GAP:  cfg_q.max_gap          <= cfg_i.data.wdata;
        CFG_MIN_SPAN: cfg_q.min_span         <= cfg_i.data.wdata;
        CFG_MIN_ALI:  cfg_q.min_ali_permille <= cfg_i.data.wdata[PermW-1:0];
        default: ;
      endcase
    end
  end

  abs_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .blk_i        (blk_i),
    .push_valid_o (push_valid),
    .push_job_o   (push_job),
    .push_ready_i (push_ready)
  );

  abs_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_job_i   (push_job),
    .push_ready_o (push_ready),
    .pop_valid_o  (pop_valid),
    .pop_job_o    (pop_job),
    .pop_ready_i  (pop_ready)
  );

  abs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_valid_i (pop_valid),
    .pop_job_i   (pop_job),
    .pop_ready_o (pop_ready),
    .seg_o       (seg_o)
  );

`ifndef SYNTH
  // An emitted segment never has a negative span.
  a_seg_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid |-> seg_o.data.seg_end >= seg_o.data.seg_start)
    else $error("segment end below segment start");

  // The score never exceeds one thousand.
  a_score_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_o.valid |-> seg_o.data.identity_score <= SCORE_MAX)
    else $error("identity score above 1000");

  // The front is busy in the cycle after it takes a block.
  a_front_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (blk_i.valid && blk_i.ready) |=> !blk_i.ready)
    else $error("front took blocks on consecutive cycles");

  // A write to an unknown index leaves the registers unchanged.
  a_cfg_ignore: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_i.valid && cfg_i.data.index != CFG_MAX_GAP && cfg_i.data.index != CFG_MIN_SPAN
     && cfg_i.data.index != CFG_MIN_ALI) |=> $stable(cfg_q))
    else $error("unknown register index changed configuration");
`endif

endmodule

/* hdl/abs_front.sv */
// Front end: takes blocks, tracks the open segment and queues segment closes.
module abs_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  abs_pkg::cfg_t cfg_i,
  abs_blk_if.sink       blk_i,
  output logic          push_valid_o,
  output abs_pkg::job_t push_job_o,
  input  logic          push_ready_i
);
  import abs_pkg::*;

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_GAP  = 2'd1;
  localparam logic [1:0] F_LAST = 2'd2;

  logic [1:0] state_q, state_d;
  blk_item_t  item_q;
  logic       have_prev_q, have_prev_d;
  coord_t     seg_first_q, seg_first_d;
  coord_t     prev_t_q, prev_t_d;
  coord_t     prev_qe_q, prev_qe_d;
  sum_t       aligned_q, aligned_d;
  sum_t       matched_q, matched_d;

  logic signed [CoordW+1:0] dt, dq, gap_lim;
  logic                     brk;
  sum_t                     blk_len, base_ali, base_mat;

  assign blk_i.ready = (state_q == F_IDLE);

  // Gap test against the previous block; overlaps give negative gaps.
  always_comb begin
    dt      = $signed({2'b00, item_q.t_start}) - $signed({2'b00, prev_t_q});
    dq      = $signed({2'b00, item_q.q_start}) - $signed({2'b00, prev_qe_q});
    gap_lim = $signed({2'b00, cfg_i.max_gap});
    brk     = have_prev_q && ((dt > gap_lim) || (dq > gap_lim));
    blk_len = (item_q.t_end >= item_q.t_start) ?
              {1'b0, item_q.t_end - item_q.t_start} : '0;
    base_ali = (brk || !have_prev_q) ? '0 : aligned_q;
    base_mat = (brk || !have_prev_q) ? '0 : matched_q;
  end

  // Sequencer: a gap-check state for each block, and a close state for a chain end.
  always_comb begin
    state_d      = state_q;
    have_prev_d  = have_prev_q;
    seg_first_d  = seg_first_q;
    prev_t_d     = prev_t_q;
    prev_qe_d    = prev_qe_q;
    aligned_d    = aligned_q;
    matched_d    = matched_q;
    push_valid_o = 1'b0;
    push_job_o   = '{first_t: seg_first_q, end_t: prev_t_q, aligned: aligned_q,
                     matched: matched_q, minus: item_q.query_minus,
                     last_job: 1'b1};
    unique case (state_q)
      F_IDLE: begin
        if (blk_i.valid) begin
          state_d = F_GAP;
        end
      end
      F_GAP: begin
        push_valid_o        = brk;
        push_job_o.last_job = !item_q.chain_last;
        if (!brk || push_ready_i) begin
          have_prev_d = 1'b1;
          if (brk || !have_prev_q) begin
            seg_first_d = item_q.t_start;
          end
          aligned_d = sat_add(base_ali, blk_len);
          matched_d = sat_add(base_mat, {1'b0, item_q.matched_bases});
          prev_t_d  = item_q.t_end;
          prev_qe_d = item_q.q_end;
          state_d   = item_q.chain_last ? F_LAST : F_IDLE;
        end
      end
      F_LAST: begin
        push_valid_o = 1'b1;
        if (push_ready_i) begin
          have_prev_d = 1'b0;
          aligned_d   = '0;
          matched_d   = '0;
          state_d     = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= F_IDLE;
      have_prev_q <= 1'b0;
      seg_first_q <= '0;
      prev_t_q    <= '0;
      prev_qe_q   <= '0;
      aligned_q   <= '0;
      matched_q   <= '0;
    end else begin
      state_q     <= state_d;
      have_prev_q <= have_prev_d;
      seg_first_q <= seg_first_d;
      prev_t_q    <= prev_t_d;
      prev_qe_q   <= prev_qe_d;
      aligned_q   <= aligned_d;
      matched_q   <= matched_d;
    end
  end

  // Input beat capture.
  always_ff @(posedge clk_i) begin
    if (blk_i.valid && blk_i.ready) begin
      item_q <= blk_i.data;
    end
  end

endmodule

/* hdl/abs_fifo.sv */
// Two-entry queue of segment closes between the front and the back.
module abs_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  input  abs_pkg::job_t push_job_i,
  output logic          push_ready_o,
  output logic          pop_valid_o,
  output abs_pkg::job_t pop_job_o,
  input  logic          pop_ready_i
);
  import abs_pkg::*;

  job_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;
  logic       do_push, do_pop;

  assign push_ready_o = (count_q != 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign pop_job_o    = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      count_q <= count_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

endmodule

/* hdl/abs_back.sv */
// Back end: qualifies each closed segment, divides out its score and emits it.
module abs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  abs_pkg::cfg_t cfg_i,
  input  logic          pop_valid_i,
  input  abs_pkg::job_t pop_job_i,
  output logic          pop_ready_o,
  abs_seg_if.source     seg_o
);
  import abs_pkg::*;

  localparam logic [2:0] B_IDLE     = 3'd0;
  localparam logic [2:0] B_MUL      = 3'd1;
  localparam logic [2:0] B_CHK      = 3'd2;
  localparam logic [2:0] B_DIV      = 3'd3;
  localparam logic [2:0] B_DONE     = 3'd4;
  localparam logic [2:0] B_PUT_HOLD = 3'd5;
  localparam logic [2:0] B_PUT_CUR  = 3'd6;

  localparam int unsigned NumW = 42;

  logic [2:0]      state_q, state_d;
  job_t            job_q;
  logic [NumW-1:0] prod_a_q, num_q, rem_q, rem_d, dsh_q, dsh_d;
  logic [NumW-2:0] prod_m_q;
  logic [PermW-1:0] quo_q, quo_d, score_q, score_d;
  logic [2:0]      cnt_q, cnt_d;
  seg_item_t       hold_q, hold_d, out_q, out_d, cur;
  logic            hold_valid_q, hold_valid_d;
  logic            cur_emit_q, cur_emit_d;
  logic            out_valid_q, out_valid_d;

  logic [SumW-1:0] cover_len;
  logic            cover_neg, cover_zero, ali_ok, span_ok, emit, out_free;

  assign pop_ready_o = (state_q == B_IDLE);
  assign seg_o.valid = out_valid_q;
  assign seg_o.data  = out_q;
  assign out_free    = !out_valid_q || seg_o.ready;

  // Covered length of the segment and the two emit tests.
  always_comb begin
    cover_len  = {1'b0, job_q.end_t} - {1'b0, job_q.first_t};
    cover_neg  = cover_len[SumW-1];
    cover_zero = (cover_len == '0);
    ali_ok     = !cover_neg && (cover_zero || (prod_a_q >= {1'b0, prod_m_q}));
    span_ok    = !cover_neg && (cover_len[CoordW-1:0] >= cfg_i.min_span);
    emit       = ali_ok && span_ok;
    cur        = '{seg_start: job_q.first_t, seg_end: job_q.end_t,
                   identity_score: score_q, seg_minus: job_q.minus, run_last: 1'b1};
  end

  // Sequencer with a two-bit-per-cycle restoring divider.
  always_comb begin
    logic [NumW-1:0]  r;
    logic [NumW-1:0]  d;
    logic [PermW-1:0] q;
    state_d      = state_q;
    rem_d        = rem_q;
    dsh_d        = dsh_q;
    quo_d        = quo_q;
    cnt_d        = cnt_q;
    score_d      = score_q;
    hold_d       = hold_q;
    hold_valid_d = hold_valid_q;
    cur_emit_d   = cur_emit_q;
    out_d        = out_q;
    out_valid_d  = (out_valid_q && seg_o.ready) ? 1'b0 : out_valid_q;
    r            = rem_q;
    d            = dsh_q;
    q            = quo_q;
    unique case (state_q)
      B_IDLE: begin
        if (pop_valid_i) begin
          state_d = B_MUL;
        end
      end
      B_MUL: begin
        state_d = B_CHK;
      end
      B_CHK: begin
        if (emit) begin
          if (job_q.aligned == '0) begin
            score_d = '0;
            state_d = B_DONE;
          end else if (num_q >= {job_q.aligned, 10'd0}) begin
            score_d = SCORE_MAX;
            state_d = B_DONE;
          end else begin
            rem_d   = num_q;
            dsh_d   = {1'b0, job_q.aligned, 9'd0};
            quo_d   = '0;
            cnt_d   = '0;
            state_d = B_DIV;
          end
        end else if (job_q.last_job && hold_valid_q) begin
          cur_emit_d = 1'b0;
          state_d    = B_PUT_HOLD;
        end else begin
          state_d = B_IDLE;
        end
      end
      B_DIV: begin
        for (int i = 0; i < 2; i++) begin
          if (r >= d) begin
            r = r - d;
            q = {q[PermW-2:0], 1'b1};
          end else begin
            q = {q[PermW-2:0], 1'b0};
          end
          d = d >> 1;
        end
        rem_d = r;
        dsh_d = d;
        quo_d = q;
        cnt_d = cnt_q + 3'd1;
        if (cnt_q == 3'd4) begin
          score_d = (q > SCORE_MAX) ? SCORE_MAX : q;
          state_d = B_DONE;
        end
      end
      B_DONE: begin
        if (!job_q.last_job) begin
          hold_d          = cur;
          hold_d.run_last = 1'b0;
          hold_valid_d    = 1'b1;
          state_d         = B_IDLE;
        end else if (hold_valid_q) begin
          cur_emit_d = 1'b1;
          state_d    = B_PUT_HOLD;
        end else begin
          state_d = B_PUT_CUR;
        end
      end
      B_PUT_HOLD: begin
        if (out_free) begin
          out_d          = hold_q;
          out_d.run_last = !cur_emit_q;
          out_valid_d    = 1'b1;
          hold_valid_d   = 1'b0;
          state_d        = cur_emit_q ? B_PUT_CUR : B_IDLE;
        end
      end
      B_PUT_CUR: begin
        if (out_free) begin
          out_d       = cur;
          out_valid_d = 1'b1;
          state_d     = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      hold_valid_q <= 1'b0;
      cur_emit_q   <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
    end else begin
      state_q      <= state_d;
      hold_valid_q <= hold_valid_d;
      cur_emit_q   <= cur_emit_d;
      out_valid_q  <= out_valid_d;
      cnt_q        <= cnt_d;
    end
  end

  // Datapath registers: job capture, products, divider and result beats.
  always_ff @(posedge clk_i) begin
    if (state_q == B_IDLE && pop_valid_i) begin
      job_q <= pop_job_i;
    end
    if (state_q == B_MUL) begin
      prod_a_q <= {10'd0, job_q.aligned} * {32'd0, SCORE_MAX};
      prod_m_q <= {31'd0, cfg_i.min_ali_permille} * {10'd0, cover_len[CoordW-1:0]};
      num_q    <= {10'd0, job_q.matched} * {32'd0, SCORE_MAX}
                  + {11'd0, job_q.aligned[SumW-1:1]};
    end
    rem_q   <= rem_d;
    dsh_q   <= dsh_d;
    quo_q   <= quo_d;
    score_q <= score_d;
    hold_q  <= hold_d;
    out_q   <= out_d;
  end

endmodule
